// ===== design/message_header_parser_macros.svh =====
// Assertion macros for the message header parser.
// Included by message_header_parser.sv; uses i_clk and i_rst_n of the includer.
`ifndef MESSAGE_HEADER_PARSER_MACROS_SVH
`define MESSAGE_HEADER_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define MHP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("message_header_parser assertion failed");
`define MHP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("message_header_parser assertion failed");
`else
`define MHP_ASSERT(lbl, prop)
`define MHP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== design/mhp_pkg.sv =====
// Shared types, constants and header length decode for the message header parser.
// No dependencies.
package mhp_pkg;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;

    localparam logic [4:0] HDR_MIN       = 5'd8;
    localparam logic [1:0] GROUP_SESSION = 2'd1;

    localparam logic [1:0] DST_NONE     = 2'd0;
    localparam logic [1:0] DST_NODE     = 2'd1;
    localparam logic [1:0] DST_GROUP    = 2'd2;
    localparam logic [1:0] DST_RESERVED = 2'd3;

    // one classified byte, front to back
    typedef struct packed {
        logic [7:0] data;
        logic [4:0] pos;
        logic       emit;
        logic [1:0] status;
        logic       with_flags;
        logic       full;
        logic [4:0] len;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  message_flags;
        logic [15:0] sess_id;
        logic [7:0]  sec_flags;
        logic [31:0] msg_counter;
        logic [63:0] source_node;
        logic [63:0] dest_node;
        logic [15:0] dest_group;
        logic [4:0]  header_length;
        logic        secure;
    } t_result;

    // header length for a flags byte, zero when the flags are invalid
    function automatic logic [4:0] hdr_need(input logic [7:0] f);
        logic [4:0] n;
        n = HDR_MIN;
        if (f[7:4] != 4'd0) begin
            return 5'd0;
        end
        if (f[2]) begin
            n = n + 5'd8;
        end
        unique case (f[1:0])
            DST_NONE:  n = n;
            DST_NODE:  n = n + 5'd8;
            DST_GROUP: n = n + 5'd2;
            default:   n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== design/mhp_front.sv =====
// Front end: tracks byte position, decides when a result is due and its status.
// Depends on mhp_pkg.
module mhp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last_byte,
    output logic          o_cmd_push,
    output mhp_pkg::t_cmd o_cmd
);

    logic [4:0] r_pos, n_pos;
    logic       r_skip, n_skip;
    logic [7:0] r_flags, n_flags;
    logic [7:0] fl;
    logic [4:0] count;
    logic [4:0] need;

    always_comb begin
        fl          = (r_pos == 5'd0) ? i_data_byte : r_flags;
        count       = r_pos + 5'd1;
        need        = mhp_pkg::hdr_need(fl);
        n_pos       = r_pos;
        n_skip      = r_skip;
        n_flags     = r_flags;
        o_cmd_push  = 1'b0;
        o_cmd.data       = i_data_byte;
        o_cmd.pos        = r_pos;
        o_cmd.emit       = 1'b0;
        o_cmd.status     = mhp_pkg::ST_OK;
        o_cmd.with_flags = 1'b0;
        o_cmd.full       = 1'b0;
        o_cmd.len        = 5'd0;
        if (i_valid) begin
            if (r_skip) begin
                if (i_last_byte) begin
                    n_skip = 1'b0;
                    n_pos  = 5'd0;
                end
            end else begin
                o_cmd_push = 1'b1;
                n_flags    = fl;
                if (count < mhp_pkg::HDR_MIN) begin
                    if (i_last_byte) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = mhp_pkg::ST_TRUNCATED;
                        n_pos        = 5'd0;
                    end else begin
                        n_pos = count;
                    end
                end else if (need == 5'd0) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.status     = mhp_pkg::ST_INVALID;
                    o_cmd.with_flags = 1'b1;
                    n_pos            = 5'd0;
                    n_skip           = !i_last_byte;
                end else if (count >= need) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.status     = mhp_pkg::ST_OK;
                    o_cmd.with_flags = 1'b1;
                    o_cmd.full       = 1'b1;
                    o_cmd.len        = need;
                    n_pos            = 5'd0;
                    n_skip           = !i_last_byte;
                end else if (i_last_byte) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.status     = mhp_pkg::ST_TRUNCATED;
                    o_cmd.with_flags = 1'b1;
                    n_pos            = 5'd0;
                end else begin
                    n_pos = count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 5'd0;
            r_skip <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_skip <= n_skip;
        end
        r_flags <= n_flags;
    end

endmodule

// ===== design/mhp_queue.sv =====
// Small FIFO of classified bytes between front and back.
// Depends on mhp_pkg.
module mhp_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  mhp_pkg::t_cmd i_data,
    input  logic          i_rd,
    output logic          o_valid,
    output logic          o_full,
    output mhp_pkg::t_cmd o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    mhp_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_wr, do_rd;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== design/mhp_back.sv =====
// Back end: assembles header fields from classified bytes and holds the result word.
// Depends on mhp_pkg.
module mhp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  mhp_pkg::t_cmd    i_cmd,
    output logic             o_cmd_pop,
    input  logic             i_pop,
    output logic             o_out_valid,
    output mhp_pkg::t_result o_result
);

    logic [7:0]  r_flags, n_flags;
    logic [15:0] r_session, n_session;
    logic [7:0]  r_security, n_security;
    logic [31:0] r_counter, n_counter;
    logic [63:0] r_source, n_source;
    logic [63:0] r_dest, n_dest;
    logic        r_out_valid;
    mhp_pkg::t_result r_result, n_result;
    logic [4:0]  rel;
    logic [4:0]  rel_dst;
    logic [1:0]  dst;

    assign o_cmd_pop   = i_cmd_valid && (!i_cmd.emit || !r_out_valid || i_pop);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_comb begin
        n_flags    = r_flags;
        n_session  = r_session;
        n_security = r_security;
        n_counter  = r_counter;
        n_source   = r_source;
        n_dest     = r_dest;
        rel        = i_cmd.pos - 5'd8;
        rel_dst    = n_flags[2] ? rel - 5'd8 : rel;
        if (i_cmd.pos == 5'd0) begin
            n_flags    = i_cmd.data;
            n_session  = 16'd0;
            n_security = 8'd0;
            n_counter  = 32'd0;
            n_source   = 64'd0;
            n_dest     = 64'd0;
            rel_dst    = rel;
        end else if (i_cmd.pos < 5'd3) begin
            n_session[{i_cmd.pos[1], 3'b000} +: 8] = i_cmd.data;
        end else if (i_cmd.pos == 5'd3) begin
            n_security = i_cmd.data;
        end else if (i_cmd.pos < 5'd8) begin
            n_counter[{i_cmd.pos[1:0], 3'b000} +: 8] = i_cmd.data;
        end else if (r_flags[2] && rel < 5'd8) begin
            n_source[{rel[2:0], 3'b000} +: 8] = i_cmd.data;
        end else if (rel_dst < 5'd8) begin
            n_dest[{rel_dst[2:0], 3'b000} +: 8] = i_cmd.data;
        end

        dst      = n_flags[1:0];
        n_result = '0;
        n_result.status = i_cmd.status;
        if (i_cmd.with_flags) begin
            n_result.message_flags = n_flags;
        end
        if (i_cmd.full) begin
            n_result.sess_id       = n_session;
            n_result.sec_flags     = n_security;
            n_result.msg_counter   = n_counter;
            n_result.source_node   = n_source;
            n_result.dest_node     = (dst == mhp_pkg::DST_NODE) ? n_dest : 64'd0;
            n_result.dest_group    = (dst == mhp_pkg::DST_GROUP) ? n_dest[15:0] : 16'd0;
            n_result.header_length = i_cmd.len;
            n_result.secure        = (n_security[1:0] == mhp_pkg::GROUP_SESSION)
                                     || (n_session != 16'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd_pop && i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_flags    <= n_flags;
            r_session  <= n_session;
            r_security <= n_security;
            r_counter  <= n_counter;
            r_source   <= n_source;
            r_dest     <= n_dest;
            if (i_cmd.emit) begin
                r_result <= n_result;
            end
        end
    end

endmodule

// ===== design/message_header_parser.sv =====
// Message header parser top level: front end, byte queue, back end.
// Depends on mhp_pkg, mhp_front, mhp_queue, mhp_back and the assertion macros.
//
// Input channel: one datagram byte per word, last_byte marks the final byte.
// A word is taken on a clock edge with push high and full low; one byte per
// cycle is sustained as long as results are taken when they appear.
// Result channel: one result word per datagram, shown while empty is low and
// taken on an edge with pop high. Empty falls at the clock edge after the one
// that takes the byte completing the header (or ending a short datagram, or
// the eighth byte of a header with invalid flags), later only if words queued
// during a stall wait ahead of it. Payload bytes after that are dropped.
// The front end classifies each header byte combinationally and writes it to a
// QUEUE_DEPTH-word queue; the back end drains one word per cycle into the
// result register. If the receiver stalls with a result held, the back end
// waits on the next result and the queue fills, then full rises; header
// bytes that produce no result still drain while stalled.
// Reset (synchronous) empties the queue and result register and starts a
// new datagram.
`include "message_header_parser_macros.svh"
module message_header_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [7:0]  o_message_flags,
    output logic [15:0] o_sess_id,
    output logic [7:0]  o_sec_flags,
    output logic [31:0] o_msg_counter,
    output logic [63:0] o_source_node,
    output logic [63:0] o_dest_node,
    output logic [15:0] o_dest_group,
    output logic [4:0]  o_header_length,
    output logic        o_secure
);

    logic             accept;
    logic             cmd_push;
    mhp_pkg::t_cmd    cmd_in;
    mhp_pkg::t_cmd    cmd_out;
    logic             cmd_valid;
    logic             cmd_pop;
    logic             out_valid;
    mhp_pkg::t_result result;
    logic             res_ok;
    logic             res_invalid;
    logic             flags_bad;

    assign accept = push && !full;

    mhp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    mhp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_push),
        .i_data  (cmd_in),
        .i_rd    (cmd_pop),
        .o_valid (cmd_valid),
        .o_full  (full),
        .o_data  (cmd_out)
    );

    mhp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_out_valid (out_valid),
        .o_result    (result)
    );

    assign empty           = !out_valid;
    assign o_status        = result.status;
    assign o_message_flags = result.message_flags;
    assign o_sess_id       = result.sess_id;
    assign o_sec_flags     = result.sec_flags;
    assign o_msg_counter   = result.msg_counter;
    assign o_source_node   = result.source_node;
    assign o_dest_node     = result.dest_node;
    assign o_dest_group    = result.dest_group;
    assign o_header_length = result.header_length;
    assign o_secure        = result.secure;

    assign res_ok      = !empty && (o_status == mhp_pkg::ST_OK);
    assign res_invalid = !empty && (o_status == mhp_pkg::ST_INVALID);
    assign flags_bad   = (o_message_flags[7:4] != 4'd0)
                         || (o_message_flags[1:0] == mhp_pkg::DST_RESERVED);

    `MHP_ASSERT_ALWAYS(a_status_legal, !empty |-> (o_status <= mhp_pkg::ST_TRUNCATED))
    `MHP_ASSERT(a_len_only_ok, (!empty && !res_ok) |-> (o_header_length == 5'd0))
    `MHP_ASSERT(a_invalid_flags, res_invalid |-> flags_bad)
    `MHP_ASSERT(a_ok_len_min, res_ok |-> (o_header_length >= mhp_pkg::HDR_MIN))

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for message_header_parser: directed and random datagrams.
// Uses mhp_pkg for the result type and status and destination codes; needs only the RTL.
module tb;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_IDLE  = 1450;
    localparam int RANDOM_TOTAL = 1750;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        pop         = 1'b0;
    logic        full;
    logic        empty;
    logic [1:0]  o_status;
    logic [7:0]  o_message_flags;
    logic [15:0] o_sess_id;
    logic [7:0]  o_sec_flags;
    logic [31:0] o_msg_counter;
    logic [63:0] o_source_node;
    logic [63:0] o_dest_node;
    logic [15:0] o_dest_group;
    logic [4:0]  o_header_length;
    logic        o_secure;

    message_header_parser u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .empty           (empty),
        .pop             (pop),
        .o_status        (o_status),
        .o_message_flags (o_message_flags),
        .o_sess_id       (o_sess_id),
        .o_sec_flags     (o_sec_flags),
        .o_msg_counter   (o_msg_counter),
        .o_source_node   (o_source_node),
        .o_dest_node     (o_dest_node),
        .o_dest_group    (o_dest_group),
        .o_header_length (o_header_length),
        .o_secure        (o_secure)
    );

    // parser state as predicted
    logic [4:0]  hp_pos;
    logic        hp_skip;
    logic [7:0]  hp_flags;
    logic [15:0] hp_session;
    logic [7:0]  hp_security;
    logic [31:0] hp_counter;
    logic [63:0] hp_source;
    logic [63:0] hp_dest;

    mhp_pkg::t_result pending_headers[$];

    bit drive_idle = 1'b1;
    bit drain_idle = 1'b1;
    int n_errors   = 0;
    int n_checked  = 0;
    int n_datagrams = 0;
    int n_bytes = 0;
    int n_ok = 0;
    int n_invalid = 0;
    int n_trunc = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int header_span(input logic [7:0] f);
        int n;
        n = int'(mhp_pkg::HDR_MIN);
        if (f[7:4] != 4'h0 || f[1:0] == mhp_pkg::DST_RESERVED) begin
            return 0;
        end
        if (f[2]) begin
            n += 8;
        end
        if (f[1:0] == mhp_pkg::DST_NODE) begin
            n += 8;
        end else if (f[1:0] == mhp_pkg::DST_GROUP) begin
            n += 2;
        end
        return n;
    endfunction

    task automatic decode_header_byte(input logic [7:0] b, input logic l);
        mhp_pkg::t_result r;
        int      pos;
        int      rel;
        int      count;
        int      need;
        bit      done;
        r    = '0;
        done = 1'b0;
        if (hp_skip) begin
            if (l) begin
                hp_skip = 1'b0;
                hp_pos  = '0;
            end
            return;
        end
        pos = int'(hp_pos);
        if (pos == 0) begin
            hp_flags    = '0;
            hp_session  = '0;
            hp_security = '0;
            hp_counter  = '0;
            hp_source   = '0;
            hp_dest     = '0;
        end
        if (pos == 0) begin
            hp_flags = b;
        end else if (pos < 3) begin
            hp_session |= 16'(b) << (8 * (pos - 1));
        end else if (pos == 3) begin
            hp_security = b;
        end else if (pos < 8) begin
            hp_counter |= 32'(b) << (8 * (pos - 4));
        end else begin
            rel = pos - 8;
            if (hp_flags[2] && rel < 8) begin
                hp_source |= 64'(b) << (8 * rel);
            end else begin
                if (hp_flags[2]) begin
                    rel -= 8;
                end
                if (rel < 8) begin
                    hp_dest |= 64'(b) << (8 * rel);
                end
            end
        end
        count = pos + 1;
        need  = header_span(hp_flags);
        if (count < int'(mhp_pkg::HDR_MIN)) begin
            if (l) begin
                r.status = mhp_pkg::ST_TRUNCATED;
                done     = 1'b1;
                n_trunc++;
            end
        end else if (need == 0) begin
            r.status        = mhp_pkg::ST_INVALID;
            r.message_flags = hp_flags;
            done            = 1'b1;
            n_invalid++;
        end else if (count >= need) begin
            r.status        = mhp_pkg::ST_OK;
            r.message_flags = hp_flags;
            r.sess_id       = hp_session;
            r.sec_flags     = hp_security;
            r.msg_counter   = hp_counter;
            r.source_node   = hp_source;
            r.dest_node     = (hp_flags[1:0] == mhp_pkg::DST_NODE) ? hp_dest : 64'd0;
            r.dest_group    = (hp_flags[1:0] == mhp_pkg::DST_GROUP) ? hp_dest[15:0] : 16'd0;
            r.header_length = 5'(need);
            r.secure        = (hp_security[1:0] == mhp_pkg::GROUP_SESSION)
                              || (hp_session != 16'd0);
            done            = 1'b1;
            n_ok++;
        end else if (l) begin
            r.status        = mhp_pkg::ST_TRUNCATED;
            r.message_flags = hp_flags;
            done            = 1'b1;
            n_trunc++;
        end
        if (done) begin
            pending_headers.push_back(r);
            hp_pos  = '0;
            hp_skip = !l;
        end else begin
            hp_pos = 5'(count);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        if (drive_idle && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            gap = $urandom_range(1, 11);
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= l;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        decode_header_byte(b, l);
    endtask

    task automatic send_datagram(input logic [7:0] flags, input logic [15:0] sess,
                                 input logic [7:0] sec, input logic [31:0] ctr,
                                 input logic [63:0] src, input logic [63:0] dst,
                                 input int len);
        logic [7:0] img[$];
        img.push_back(flags);
        img.push_back(sess[7:0]);
        img.push_back(sess[15:8]);
        img.push_back(sec);
        for (int k = 0; k < 4; k++) img.push_back(ctr[8*k +: 8]);
        if (flags[2]) begin
            for (int k = 0; k < 8; k++) img.push_back(src[8*k +: 8]);
        end
        if (flags[1:0] == mhp_pkg::DST_NODE) begin
            for (int k = 0; k < 8; k++) img.push_back(dst[8*k +: 8]);
        end else if (flags[1:0] == mhp_pkg::DST_GROUP) begin
            for (int k = 0; k < 2; k++) img.push_back(dst[8*k +: 8]);
        end
        while (img.size() < len) img.push_back(8'($urandom));
        n_bytes += len;
        n_datagrams++;
        for (int k = 0; k < len; k++) send_byte(img[k], k == len - 1);
    endtask

    task automatic test_short_datagrams();
        send_datagram(8'hFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, '1, '1, 1);
        send_datagram(8'h00, 16'h0000, 8'h00, 32'h0000_0000, '0, '0, 7);
    endtask

    task automatic test_invalid_flags();
        // version nonzero, payload after it is dropped
        send_datagram(8'hF0, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, '1, '1, 12);
        // reserved destination, exactly eight bytes
        send_datagram(8'h03, 16'h1234, 8'h01, 32'hDEAD_BEEF, '0, '0, 8);
        // invalid flags but too short: truncation wins
        send_datagram(8'h13, 16'h1111, 8'h22, 32'h3333_3333, '0, '0, 5);
    endtask

    task automatic test_truncated_header();
        send_datagram(8'h05, 16'hABCD, 8'h00, 32'h0102_0304, '1, '1, 20);
        send_datagram(8'h02, 16'h0000, 8'h01, 32'h0000_0001, '0, '1, 9);
    endtask

    task automatic test_valid_headers();
        send_datagram(8'h00, 16'h0000, 8'h00, 32'h0000_0000, '0, '0, 8);
        send_datagram(8'h06, 16'h0000, 8'h01, 32'hFFFF_FFFF, '1, '1, 18);
        send_datagram(8'h05, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, '1, '1, 24);
        send_datagram(8'h09, 16'h8001, 8'hFE, 32'h8000_0001,
                      64'h0, 64'h8000_0000_0000_0001, 16);
    endtask

    task automatic test_payload_skip();
        send_datagram(8'h04, 16'h0001, 8'h02, 32'h0000_00FF, 64'h0123_4567_89AB_CDEF, '0, 22);
        send_datagram(8'h02, 16'hFFFF, 8'h03, 32'h7FFF_FFFF, '0, 64'hBEEF, 13);
    endtask

    task automatic test_random_traffic(input int target);
        logic [7:0]  flags;
        logic [15:0] sess;
        int          choice;
        int          shape;
        int          span;
        int          len;
        while (n_bytes < target) begin
            choice = $urandom_range(0, 99);
            if (choice < 75) begin
                flags = {4'h0, 1'($urandom), 1'($urandom), 2'($urandom_range(0, 2))};
            end else if (choice < 90) begin
                flags = 8'($urandom);
            end else begin
                flags = {4'($urandom), 2'($urandom), mhp_pkg::DST_RESERVED};
            end
            span = header_span(flags);
            if (span == 0) begin
                span = int'(mhp_pkg::HDR_MIN);
            end
            shape = $urandom_range(0, 9);
            if (shape < 6) begin
                len = span + $urandom_range(0, 3);
            end else if (shape < 8) begin
                len = (span > int'(mhp_pkg::HDR_MIN))
                      ? $urandom_range(mhp_pkg::HDR_MIN, span - 1)
                      : $urandom_range(1, 7);
            end else if (shape == 8) begin
                len = $urandom_range(1, 7);
            end else begin
                len = span + $urandom_range(4, 12);
            end
            sess = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
            send_datagram(flags, sess, 8'($urandom), $urandom,
                          {$urandom, $urandom}, {$urandom, $urandom}, len);
        end
    endtask

    task automatic test_back_to_back();
        drive_idle = 1'b0;
        drain_idle = 1'b0;
        test_random_traffic(RANDOM_TOTAL);
    endtask

    task automatic note_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
        if (want !== got) begin
            n_errors++;
            if (n_errors <= 10) begin
                $display("mismatch %s: expected %h, got %h", name, want, got);
            end
        end
    endtask

    // result checker
    always @(posedge i_clk) begin : result_check
        mhp_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_headers.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("unexpected result word: status %0d flags %h",
                             o_status, o_message_flags);
                end
            end else begin
                want = pending_headers.pop_front();
                n_checked++;
                note_field("status", 64'(want.status), 64'(o_status));
                note_field("message_flags", 64'(want.message_flags), 64'(o_message_flags));
                note_field("sess_id", 64'(want.sess_id), 64'(o_sess_id));
                note_field("sec_flags", 64'(want.sec_flags), 64'(o_sec_flags));
                note_field("msg_counter", 64'(want.msg_counter), 64'(o_msg_counter));
                note_field("source_node", want.source_node, o_source_node);
                note_field("dest_node", want.dest_node, o_dest_node);
                note_field("dest_group", 64'(want.dest_group), 64'(o_dest_group));
                note_field("header_length", 64'(want.header_length), 64'(o_header_length));
                note_field("secure", 64'(want.secure), 64'(o_secure));
            end
        end
    end

    // receiver side
    initial begin : drain_side
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (drain_idle && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                gap = $urandom_range(1, 11);
                repeat (gap) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("message_header_parser verification failed");
        $finish;
    end

    initial begin
        hp_pos      = '0;
        hp_skip     = 1'b0;
        hp_flags    = '0;
        hp_session  = '0;
        hp_security = '0;
        hp_counter  = '0;
        hp_source   = '0;
        hp_dest     = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_short_datagrams();
        test_invalid_flags();
        test_truncated_header();
        test_valid_headers();
        test_payload_skip();
        test_random_traffic(RANDOM_IDLE);
        test_back_to_back();
        push <= 1'b0;
        while (pending_headers.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("covered %0d datagrams, %0d bytes, idle bursts on both sides then none",
                 n_datagrams, n_bytes);
        $display("results checked %0d: ok %0d, invalid %0d, truncated %0d, errors %0d",
                 n_checked, n_ok, n_invalid, n_trunc, n_errors);
        if (n_errors == 0) begin
            $display("message_header_parser verification clean");
        end else begin
            $display("message_header_parser verification failed");
        end
        $finish;
    end

endmodule
